// File: rtl/core/life_automaton_grid_stepper_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the life grid stepper
// Shared concurrent assertion forms used by the checker of the core.
// ---------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GRID_STEPPER_CORE_DEFINES_SVH
`define LIFE_AUTOMATON_GRID_STEPPER_CORE_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define LAGS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define LAGS_ASSERT(lbl, prop, msg) `LAGS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/lags_pkg.sv
// ---------------------------------------------------------------------------
// lags_pkg
// Sizes, field layout and codes shared by the life grid stepper files.
// ---------------------------------------------------------------------------
`default_nettype none

package lags_pkg;

  // Grid bounds.
  localparam int unsigned MAX_ROWS = 16;
  localparam int unsigned MAX_COLS = 32;

  // Field widths.
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned COL_W     = 5;
  localparam int unsigned GRID_WW   = 6;
  localparam int unsigned GRID_HW   = 5;
  localparam int unsigned GEN_W     = 63;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Row store: both boards in one memory, addressed by {board, row}.
  localparam int unsigned STORE_DEPTH = 2 * MAX_ROWS;

  // Stream layout.
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned IN_ROW_LSB     = 0;
  localparam int unsigned IN_COL_LSB     = IN_ROW_LSB + ROW_W;
  localparam int unsigned IN_CELL_BIT    = IN_COL_LSB + COL_W;
  localparam int unsigned OUT_TDATA_W    = 72;
  localparam int unsigned OUT_CELL_BIT   = 0;
  localparam int unsigned OUT_ALIVE_BIT  = 1;
  localparam int unsigned OUT_GEN_LSB    = 2;
  localparam int unsigned OUT_FIN_BIT    = OUT_GEN_LSB + GEN_W;
  localparam int unsigned OUT_PAD_W      = OUT_TDATA_W - OUT_FIN_BIT - 1;

  // Commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Register selects (paddr bit 2).
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/life_automaton_grid_stepper_core.sv
// ---------------------------------------------------------------------------
// life_automaton_grid_stepper_core
// Two-state cell grid with write, read, clear and generation step commands.
// ---------------------------------------------------------------------------
// Usage. Commands arrive as beats on the slave stream: tuser carries the
// command, tdata the row, column and cell value. Every command beat gives
// exactly one result beat on the master stream with the read cell, the live
// flag, the generation count and the finished flag.
// The grid is sized by two APB registers, grid_width at 0x0 and grid_height
// at 0x4; they should only be written while no command is in flight.
// A write passes through the modify state and a read through the cell
// read state before the emit state registers the result; a clear goes
// straight to the emit state. A step walks each grid row one cell per cycle
// through a single shared neighbour-count unit, fed by three row buffers
// that are refilled from the row store once per row. Only one command is in
// progress at a time and the next one is taken the cycle after a result
// is registered.
// Reset clears the row valid bits of both boards at once, so every cell
// reads as dead, board A is current and the generation count is zero; no
// clearing pass is needed and the block is ready in the first cycle after
// reset. If the receiver stalls, the result waits in the output register;
// the next command is still accepted and runs, and only its result waits
// until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module life_automaton_grid_stepper_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Command stream.
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // tdata: row_addr[3:0], col_addr[8:4], cell_in[9], zero padding above
  input  wire logic [lags_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [lags_pkg::CMD_W-1:0]         s_axis_tuser,
  // Result stream.
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: cell_out[0], any_alive[1], generation[64:2], finished[65],
  // zero padding above
  output      logic [lags_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lags_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [lags_pkg::PDATA_W-1:0]       pwdata,
  output      logic [lags_pkg::PDATA_W-1:0]       prdata,
  output      logic                               pready
);

  localparam int unsigned SAW = $clog2(lags_pkg::STORE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR_MOD,
    S_RD_CELL,
    S_STEP_FETCH,
    S_STEP_LOAD,
    S_STEP_CELL,
    S_STEP_WRITE,
    S_STEP_DONE,
    S_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [lags_pkg::GRID_WW-1:0] grid_width_q;
  logic [lags_pkg::GRID_HW-1:0] grid_height_q;

  // Latched command fields.
  logic [lags_pkg::ROW_W-1:0] row_q;
  logic [lags_pkg::COL_W-1:0] col_q;
  logic                       val_q;

  // Board state: current board select, one valid bit per stored row.
  logic                                        sel_q;
  logic [1:0][lags_pkg::MAX_ROWS-1:0]          valid_q;
  logic [lags_pkg::GEN_W-1:0]                  gen_q;

  // Step datapath: row fetch counter, column counter and line buffers.
  logic [lags_pkg::ROW_W:0]    fetch_q;
  logic [lags_pkg::COL_W-1:0]  ccol_q;
  logic [lags_pkg::MAX_COLS-1:0] up_q, mid_q, dn_q, nrow_q;
  logic                        alive_q;

  // Result and output register.
  logic                              res_cell_q, res_alive_q, res_fin_q;
  logic                              out_valid_q;
  logic [lags_pkg::OUT_TDATA_W-1:0]  out_tdata_q;

  // Row store signals.
  logic                          ram_we;
  logic [SAW-1:0]                ram_waddr, ram_raddr;
  logic [lags_pkg::MAX_COLS-1:0] ram_wdata, ram_rdata;

  lags_ram #(
    .WIDTH (lags_pkg::MAX_COLS),
    .DEPTH (lags_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Input field views.
  logic [lags_pkg::ROW_W-1:0] in_row;
  logic [lags_pkg::COL_W-1:0] in_col;
  logic                       in_accept;

  assign in_row    = s_axis_tdata[lags_pkg::IN_ROW_LSB +: lags_pkg::ROW_W];
  assign in_col    = s_axis_tdata[lags_pkg::IN_COL_LSB +: lags_pkg::COL_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Grid size as seen by the logic: register values above the bounds are
  // treated as the bound.
  logic [lags_pkg::GRID_WW-1:0] eff_w;
  logic [lags_pkg::GRID_HW-1:0] eff_h;

  assign eff_w = (grid_width_q > lags_pkg::GRID_WW'(lags_pkg::MAX_COLS)) ?
                 lags_pkg::GRID_WW'(lags_pkg::MAX_COLS) : grid_width_q;
  assign eff_h = (grid_height_q > lags_pkg::GRID_HW'(lags_pkg::MAX_ROWS)) ?
                 lags_pkg::GRID_HW'(lags_pkg::MAX_ROWS) : grid_height_q;

  logic [lags_pkg::MAX_COLS-1:0] col_mask;

  always_comb begin
    for (int i = 0; i < lags_pkg::MAX_COLS; i++) begin
      col_mask[i] = (i < int'(eff_w));
    end
  end

  logic in_grid;
  assign in_grid = ({1'b0, row_q} < eff_h) && ({1'b0, col_q} < eff_w);

  // Stored row of the latched command; a row never written reads as dead.
  logic [lags_pkg::MAX_COLS-1:0] cmd_row;
  assign cmd_row = valid_q[sel_q][row_q] ? ram_rdata : '0;

  // Row arriving for the line buffers, clipped to the grid in use.
  logic                          fetch_in_grid;
  logic [lags_pkg::MAX_COLS-1:0] fetch_row;

  assign fetch_in_grid = (fetch_q < eff_h);
  assign fetch_row = (fetch_in_grid && valid_q[sel_q][fetch_q[lags_pkg::ROW_W-1:0]]) ?
                     (ram_rdata & col_mask) : '0;

  // Shared neighbour-count unit: a 3x3 window at the current column.
  logic [lags_pkg::MAX_COLS+1:0] up_pad, mid_pad, dn_pad;
  logic [2:0]                    up_win, mid_win, dn_win;
  logic [3:0]                    nbr_cnt;
  logic                          new_cell;

  assign up_pad  = {1'b0, up_q, 1'b0};
  assign mid_pad = {1'b0, mid_q, 1'b0};
  assign dn_pad  = {1'b0, dn_q, 1'b0};
  assign up_win  = up_pad[{1'b0, ccol_q} +: 3];
  assign mid_win = mid_pad[{1'b0, ccol_q} +: 3];
  assign dn_win  = dn_pad[{1'b0, ccol_q} +: 3];

  assign nbr_cnt = 4'(up_win[0]) + 4'(up_win[1]) + 4'(up_win[2])
                 + 4'(mid_win[0]) + 4'(mid_win[2])
                 + 4'(dn_win[0]) + 4'(dn_win[1]) + 4'(dn_win[2]);
  assign new_cell = (nbr_cnt == 4'd3) || (mid_win[1] && (nbr_cnt == 4'd2));

  logic last_col;
  assign last_col = ({1'b0, ccol_q} == (eff_w - 1'b1));

  // Row written back by a step.
  logic [lags_pkg::ROW_W:0]   out_row_full;
  logic [lags_pkg::ROW_W-1:0] out_row;
  assign out_row_full = fetch_q - 1'b1;
  assign out_row      = out_row_full[lags_pkg::ROW_W-1:0];

  logic [lags_pkg::GEN_W-1:0] gen_inc;
  assign gen_inc = gen_q + 1'b1;

  // Row store access per state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {sel_q, row_q};
    ram_wdata = cmd_row;
    ram_raddr = {sel_q, row_q};
    case (state_q)
      S_IDLE: begin
        ram_raddr = {sel_q, in_row};
      end
      S_WR_MOD: begin
        ram_we             = in_grid;
        ram_wdata[col_q]   = val_q;
      end
      S_STEP_FETCH: begin
        ram_raddr = {sel_q, fetch_q[lags_pkg::ROW_W-1:0]};
      end
      S_STEP_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = {~sel_q, out_row};
        ram_wdata = nrow_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, board state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      grid_width_q  <= lags_pkg::GRID_WW'(10);
      grid_height_q <= lags_pkg::GRID_HW'(10);
      row_q         <= '0;
      col_q         <= '0;
      val_q         <= 1'b0;
      sel_q         <= 1'b0;
      valid_q       <= '0;
      gen_q         <= '0;
      fetch_q       <= '0;
      ccol_q        <= '0;
      up_q          <= '0;
      mid_q         <= '0;
      dn_q          <= '0;
      nrow_q        <= '0;
      alive_q       <= 1'b0;
      res_cell_q    <= 1'b0;
      res_alive_q   <= 1'b0;
      res_fin_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_tdata_q   <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == lags_pkg::REG_GRID_HEIGHT) begin
          grid_height_q <= pwdata[lags_pkg::GRID_HW-1:0];
        end else begin
          grid_width_q <= pwdata[lags_pkg::GRID_WW-1:0];
        end
      end

      // In the emit state the output register is reloaded below instead.
      if (out_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            row_q       <= in_row;
            col_q       <= in_col;
            val_q       <= s_axis_tdata[lags_pkg::IN_CELL_BIT];
            res_cell_q  <= 1'b0;
            res_alive_q <= 1'b0;
            res_fin_q   <= 1'b0;
            case (lags_pkg::cmd_e'(s_axis_tuser))
              lags_pkg::CMD_WRITE: begin
                state_q <= S_WR_MOD;
              end
              lags_pkg::CMD_READ: begin
                state_q <= S_RD_CELL;
              end
              lags_pkg::CMD_CLEAR: begin
                valid_q <= '0;
                sel_q   <= 1'b0;
                gen_q   <= '0;
                state_q <= S_EMIT;
              end
              lags_pkg::CMD_STEP: begin
                // Every row of the next board not produced below reads dead.
                valid_q[~sel_q] <= '0;
                fetch_q <= '0;
                up_q    <= '0;
                mid_q   <= '0;
                dn_q    <= '0;
                alive_q <= 1'b0;
                state_q <= S_STEP_FETCH;
              end
              default: begin
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_WR_MOD: begin
          if (in_grid) begin
            valid_q[sel_q][row_q] <= 1'b1;
          end
          state_q <= S_EMIT;
        end
        S_RD_CELL: begin
          res_cell_q <= in_grid && cmd_row[col_q];
          state_q    <= S_EMIT;
        end
        S_STEP_FETCH: begin
          state_q <= S_STEP_LOAD;
        end
        S_STEP_LOAD: begin
          up_q  <= mid_q;
          mid_q <= dn_q;
          dn_q  <= fetch_row;
          if (fetch_q == '0) begin
            // Only the first row is in the buffers; nothing to compute yet.
            if (eff_h == '0) begin
              state_q <= S_STEP_DONE;
            end else begin
              fetch_q <= fetch_q + 1'b1;
              state_q <= S_STEP_FETCH;
            end
          end else begin
            nrow_q <= '0;
            ccol_q <= '0;
            if (eff_w == '0) begin
              state_q <= S_STEP_WRITE;
            end else begin
              state_q <= S_STEP_CELL;
            end
          end
        end
        S_STEP_CELL: begin
          nrow_q[ccol_q] <= new_cell;
          if (new_cell) begin
            alive_q <= 1'b1;
          end
          if (last_col) begin
            state_q <= S_STEP_WRITE;
          end else begin
            ccol_q <= ccol_q + 1'b1;
          end
        end
        S_STEP_WRITE: begin
          valid_q[~sel_q][out_row] <= 1'b1;
          if (fetch_q == eff_h) begin
            state_q <= S_STEP_DONE;
          end else begin
            fetch_q <= fetch_q + 1'b1;
            state_q <= S_STEP_FETCH;
          end
        end
        S_STEP_DONE: begin
          sel_q       <= ~sel_q;
          gen_q       <= gen_inc;
          res_alive_q <= alive_q;
          res_fin_q   <= !alive_q || (gen_inc == '0);
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_tdata_q <= {{lags_pkg::OUT_PAD_W{1'b0}}, res_fin_q, gen_q,
                            res_alive_q, res_cell_q};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lags_pkg::REG_GRID_HEIGHT) ?
                  lags_pkg::PDATA_W'(grid_height_q) : lags_pkg::PDATA_W'(grid_width_q);

endmodule

`default_nettype wire

// File: rtl/core/lags_ram.sv
// ---------------------------------------------------------------------------
// lags_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lags_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/lags_checker.sv
// ---------------------------------------------------------------------------
// lags_checker
// Port-level checks on the life grid stepper, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "life_automaton_grid_stepper_core_defines.svh"

module lags_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [lags_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                       out_cell, out_alive, out_fin, gen_zero;
  logic                       in_beat, out_stall;
  logic [lags_pkg::GEN_W-1:0] out_gen;

  assign out_cell  = m_axis_tdata[lags_pkg::OUT_CELL_BIT];
  assign out_alive = m_axis_tdata[lags_pkg::OUT_ALIVE_BIT];
  assign out_fin   = m_axis_tdata[lags_pkg::OUT_FIN_BIT];
  assign out_gen   = m_axis_tdata[lags_pkg::OUT_GEN_LSB +: lags_pkg::GEN_W];
  assign gen_zero  = (out_gen == '0);
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A result beat that is not taken stays as it is.
  `LAGS_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "beat changed")

  // Every accepted command moves the sequencer out of the idle state and drops tready.
  `LAGS_ASSERT(a_busy_after_accept, in_beat |=> !s_axis_tready, "command taken twice in a row")

  // Only a read reports a cell and only a step reports life.
  `LAGS_ASSERT(a_cell_or_alive, m_axis_tvalid |-> !(out_cell && out_alive), "cell and life set")

  // With live cells, a step is finished only when the counter wrapped.
  `LAGS_ASSERT(a_finished_rule, m_axis_tvalid && out_alive |-> out_fin == gen_zero, "bad finished")

endmodule

bind life_automaton_grid_stepper_core lags_checker u_lags_checker (.*);

`default_nettype wire
